>>> rtl/slms_pkg.sv
// Shared types and constants for the scrolling LED matrix row scanner.
// No dependencies.
package slms_pkg;

	localparam int STORE_COLUMNS   = 256;
	localparam int DISPLAY_COLUMNS = 15;
	localparam int DISPLAY_ROWS    = 7;
	localparam int COLUMN_W        = 7;
	localparam int STORE_AW        = $clog2(STORE_COLUMNS);
	localparam int MSG_W           = 9;
	localparam int OFFSET_W        = 8;
	localparam int ROW_W           = $clog2(DISPLAY_ROWS);
	localparam int CNT_W           = $clog2(DISPLAY_COLUMNS);

	localparam logic [MSG_W-1:0] MSG_RESET = 9'd10;

	localparam logic ACTION_WRITE = 1'b0;
	localparam logic ACTION_SCAN  = 1'b1;

	typedef struct packed {
		logic                action;
		logic [7:0]          column_index;
		logic [COLUMN_W-1:0] column_data;
		logic [OFFSET_W-1:0] scroll_offset;
	} in_t;

	typedef struct packed {
		logic [14:0] column_bits;
		logic [6:0]  row_select;
	} out_t;

	// sequencer to datapath
	typedef struct packed {
		logic idle;
		logic div_en;
		logic rd_en;
		logic emit_en;
	} ctrl_t;

endpackage

>>> rtl/scrolling_led_matrix_row_scanner.sv
// Scrolling LED matrix row scanner: a write stores one column; a scan gives its
// result after 8 remainder steps of the offset, 15 column-store reads, one drain
// and one emit (which waits while the output is stalled), and no new item is taken
// until the emit is done; writes are taken every cycle when not scanning.
// Asynchronous active-low reset clears row counter, sequencer and output valid;
// the column store is not cleared and message_columns resets to 10.
module scrolling_led_matrix_row_scanner
	import slms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [MSG_W-1:0] cfg_data
);

	ctrl_t                      ctrl;
	logic                       scan_go;
	logic                       wr_en;
	logic                       out_free;
	logic                       out_valid_q;
	out_t                       out_q;
	logic [MSG_W-1:0]           msg_cols_q;
	logic [DISPLAY_COLUMNS-1:0] col_bits;
	logic [DISPLAY_ROWS-1:0]    row_sel;

	assign in_stall  = !ctrl.idle;
	assign cfg_ready = ctrl.idle;
	assign scan_go   = in_valid && ctrl.idle && (in_data.action == ACTION_SCAN);
	assign wr_en     = in_valid && ctrl.idle && (in_data.action == ACTION_WRITE);
	assign out_free  = !out_valid_q || !out_stall;

	slms_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.scan_go  (scan_go),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	slms_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.wr_en         (wr_en),
		.wr_index      (in_data.column_index),
		.wr_data       (in_data.column_data),
		.scan_go       (scan_go),
		.scroll_offset (in_data.scroll_offset),
		.msg_cols      (msg_cols_q),
		.column_bits   (col_bits),
		.row_select    (row_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_cols_q  <= MSG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				msg_cols_q <= cfg_data;
			if (ctrl.emit_en)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_en) begin
			out_q.column_bits <= 15'(col_bits);
			out_q.row_select  <= 7'(row_sel);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.action == ACTION_SCAN) |=> in_stall)
		else $error("scan accepted but next item not held off");

	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(out_data.row_select))
		else $error("row select not one-hot");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.action == ACTION_WRITE && !out_valid)
		|=> !out_valid)
		else $error("write transaction produced a result");
`endif

endmodule

>>> rtl/slms_seq.sv
// Microcoded sequencer: program ROM, step counter and loop counter.
// Depends on slms_pkg.
module slms_seq
	import slms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  scan_go,
	input  logic  out_free,
	output ctrl_t ctrl
);

	localparam logic [2:0] OP_WAIT = 3'd0;
	localparam logic [2:0] OP_DIV  = 3'd1;
	localparam logic [2:0] OP_READ = 3'd2;
	localparam logic [2:0] OP_NOP  = 3'd3;
	localparam logic [2:0] OP_EMIT = 3'd4;

	localparam logic [1:0] C_ALWAYS   = 2'd0;
	localparam logic [1:0] C_SCAN     = 2'd1;
	localparam logic [1:0] C_CNT_ZERO = 2'd2;
	localparam logic [1:0] C_OUT_FREE = 2'd3;

	localparam logic [2:0] ST_WAIT  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(OFFSET_W - 1);
	localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(DISPLAY_COLUMNS - 1);
	localparam logic [CNT_W-1:0] CNT_NONE  = '0;

	typedef struct packed {
		logic [2:0]       op;
		logic [1:0]       cond;
		logic [2:0]       target;
		logic [CNT_W-1:0] cnt_init;
	} uword_t;

	logic [2:0]       pc_q;
	logic [CNT_W-1:0] cnt_q;
	uword_t           uw;
	logic             taken;

	// program
	always_comb begin
		case (pc_q)
			ST_WAIT:  uw = '{OP_WAIT, C_SCAN,     ST_DIV,   DIV_LAST};
			ST_DIV:   uw = '{OP_DIV,  C_CNT_ZERO, ST_READ,  READ_LAST};
			ST_READ:  uw = '{OP_READ, C_CNT_ZERO, ST_DRAIN, CNT_NONE};
			ST_DRAIN: uw = '{OP_NOP,  C_ALWAYS,   ST_EMIT,  CNT_NONE};
			ST_EMIT:  uw = '{OP_EMIT, C_OUT_FREE, ST_WAIT,  CNT_NONE};
			default:  uw = '{OP_NOP,  C_ALWAYS,   ST_WAIT,  CNT_NONE};
		endcase
	end

	always_comb begin
		case (uw.cond)
			C_ALWAYS:   taken = 1'b1;
			C_SCAN:     taken = scan_go;
			C_CNT_ZERO: taken = (cnt_q == '0);
			C_OUT_FREE: taken = out_free;
			default:    taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= ST_WAIT;
			cnt_q <= '0;
		end else if (taken) begin
			pc_q  <= uw.target;
			cnt_q <= uw.cnt_init;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign ctrl.idle    = (uw.op == OP_WAIT);
	assign ctrl.div_en  = (uw.op == OP_DIV);
	assign ctrl.rd_en   = (uw.op == OP_READ);
	assign ctrl.emit_en = (uw.op == OP_EMIT) && taken;

endmodule

>>> rtl/slms_datapath.sv
// Datapath: column store, serial remainder unit, column shift register, row counter.
// Depends on slms_pkg.
module slms_datapath
	import slms_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctrl_t                       ctrl,
	input  logic                        wr_en,
	input  logic [STORE_AW-1:0]         wr_index,
	input  logic [COLUMN_W-1:0]         wr_data,
	input  logic                        scan_go,
	input  logic [OFFSET_W-1:0]         scroll_offset,
	input  logic [MSG_W-1:0]            msg_cols,
	output logic [DISPLAY_COLUMNS-1:0]  column_bits,
	output logic [DISPLAY_ROWS-1:0]     row_select
);

	logic [COLUMN_W-1:0]        mem [STORE_COLUMNS];
	logic [COLUMN_W-1:0]        rd_q;
	logic                       rd_s1;
	logic [STORE_AW-1:0]        idx_q;
	logic [OFFSET_W-1:0]        dvd_q;
	logic [DISPLAY_COLUMNS-1:0] bits_q;
	logic [ROW_W-1:0]           row_q;
	logic [MSG_W-1:0]           modulus;
	logic [MSG_W-1:0]           trial;
	logic [MSG_W-1:0]           idx_inc;

	always_comb begin
		if (msg_cols == '0)
			modulus = MSG_W'(1);
		else if (msg_cols > MSG_W'(STORE_COLUMNS))
			modulus = MSG_W'(STORE_COLUMNS);
		else
			modulus = msg_cols;
	end

	assign trial   = {idx_q, dvd_q[OFFSET_W-1]};
	assign idx_inc = {1'b0, idx_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_index] <= wr_data;
		if (ctrl.rd_en)
			rd_q <= mem[idx_q];
	end

	// idx_q holds the partial remainder, then walks the wrapped column index
	always_ff @(posedge clk) begin
		if (scan_go) begin
			idx_q <= '0;
			dvd_q <= scroll_offset;
		end else if (ctrl.div_en) begin
			idx_q <= (trial >= modulus) ? STORE_AW'(trial - modulus) : STORE_AW'(trial);
			dvd_q <= dvd_q << 1;
		end else if (ctrl.rd_en) begin
			idx_q <= (idx_inc == modulus) ? '0 : STORE_AW'(idx_inc);
		end
		if (rd_s1)
			bits_q <= {rd_q[row_q], bits_q[DISPLAY_COLUMNS-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			row_q <= '0;
		end else begin
			rd_s1 <= ctrl.rd_en;
			if (ctrl.emit_en)
				row_q <= (row_q == ROW_W'(DISPLAY_ROWS - 1)) ? '0 : row_q + 1'b1;
		end
	end

	assign column_bits = bits_q;
	assign row_select  = DISPLAY_ROWS'(1) << row_q;

endmodule
